>>> rtl/blv_pkg.sv
package blv_pkg;

  localparam int ELEMENT_COUNT_DEF = 1024;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] Q_MAX64 = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] Q_MIN64 = 64'shffff_ffff_8000_0000;

  // configuration register indexes
  localparam logic [2:0] CFG_SURFACE   = 3'd0;
  localparam logic [2:0] CFG_BASE_XX   = 3'd1;
  localparam logic [2:0] CFG_BASE_YY   = 3'd2;
  localparam logic [2:0] CFG_BASE_XY   = 3'd3;
  localparam logic [2:0] CFG_GRAD_XX   = 3'd4;
  localparam logic [2:0] CFG_GRAD_YY   = 3'd5;
  localparam logic [2:0] CFG_LINING    = 3'd6;

  // boundary condition codes
  localparam logic [4:0] BC_SUB_A   = 5'd1;
  localparam logic [4:0] BC_PASS_A  = 5'd2;
  localparam logic [4:0] BC_NORM_A  = 5'd3;
  localparam logic [4:0] BC_SHEAR_A = 5'd4;
  localparam logic [4:0] BC_SUB_B   = 5'd5;
  localparam logic [4:0] BC_JOINT_A = 5'd6;
  localparam logic [4:0] BC_PASS_B  = 5'd7;
  localparam logic [4:0] BC_SUB_C   = 5'd11;
  localparam logic [4:0] BC_PASS_C  = 5'd12;
  localparam logic [4:0] BC_NORM_B  = 5'd13;
  localparam logic [4:0] BC_SHEAR_B = 5'd14;
  localparam logic [4:0] BC_SUB_D   = 5'd15;
  localparam logic [4:0] BC_JOINT_B = 5'd16;
  localparam logic [4:0] BC_PASS_D  = 5'd17;

  // joint pairing flag
  localparam logic [1:0] PAIR_SUB  = 2'd1;
  localparam logic [1:0] PAIR_ZERO = 2'd2;

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [32:0] r;
    r = {a[31], a} + {b[31], b};
    if (r[32] != r[31]) begin
      qadd = r[32] ? Q_MIN : Q_MAX;
    end else begin
      qadd = r[31:0];
    end
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [32:0] r;
    r = {a[31], a} - {b[31], b};
    if (r[32] != r[31]) begin
      qsub = r[32] ? Q_MIN : Q_MAX;
    end else begin
      qsub = r[31:0];
    end
  endfunction

  // round to nearest, ties toward +inf, then saturate
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] q;
    p = (64'(a) * 64'(b)) + 64'sd32768;
    q = p >>> 16;
    if (q > Q_MAX64) begin
      qmul = Q_MAX;
    end else if (q < Q_MIN64) begin
      qmul = Q_MIN;
    end else begin
      qmul = q[31:0];
    end
  endfunction

  function automatic logic signed [31:0] qneg(input logic signed [31:0] a);
    qneg = (a == Q_MIN) ? Q_MAX : -a;
  endfunction

  function automatic logic signed [31:0] qdbl(input logic signed [31:0] a);
    if (a[31] != a[30]) begin
      qdbl = a[31] ? Q_MIN : Q_MAX;
    end else begin
      qdbl = {a[30:0], 1'b0};
    end
  endfunction

endpackage

>>> rtl/boundary_load_vector.sv
// Boundary element right-hand-side builder.
// Requests enter on start with the element fields; busy stays low, so a
// request is taken in every cycle that start is high. Each request yields
// exactly one result, shown for one cycle with done high once the request has
// passed through every register stage (one result per cycle at full rate).
// The nine register stages follow the chain of Q16.16 products: depth,
// gradient terms, in-situ stresses, then the rotation products taken one
// multiply per stage, the sums, the boundary-code selection and the force
// products. Results leave in request order.
// The receiver cannot stall: done is a one-cycle strobe and the result ports
// hold their value only for that cycle.
// Configuration writes go through cfg_valid/cfg_ready (ready is always high)
// with cfg_index selecting the register; write only while no request is in
// flight. Reset (rst, synchronous) clears every configuration register to
// zero and empties the pipeline; results of requests in flight are dropped.
module boundary_load_vector import blv_pkg::*; #(
  parameter int ELEMENT_COUNT = ELEMENT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [$clog2(ELEMENT_COUNT)-1:0]  element_index,
  input  logic signed [31:0]                elem_y,
  input  logic signed [17:0]                cos_angle,
  input  logic signed [17:0]                sin_angle,
  input  logic [4:0]                        bc_code,
  input  logic [3:0]                        material,
  input  logic [3:0]                        next_material,
  input  logic [1:0]                        pair_flag,
  input  logic signed [31:0]                rhs_shear_in,
  input  logic signed [31:0]                rhs_normal_in,
  input  logic signed [31:0]                water_load,
  input  logic [30:0]                       half_length,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [31:0]                       cfg_data,
  output logic                              done,
  output logic [$clog2(ELEMENT_COUNT)-1:0]  index_out,
  output logic                              rhs_written,
  output logic signed [31:0]                rhs_shear_out,
  output logic signed [31:0]                rhs_normal_out,
  output logic signed [31:0]                force_shear,
  output logic signed [31:0]                force_normal
);

  localparam int IdxW   = $clog2(ELEMENT_COUNT);
  localparam int Stages = 9;

  typedef struct packed {
    logic [IdxW-1:0]    idx;
    logic signed [17:0] c;
    logic signed [17:0] s;
    logic [4:0]         code;
    logic               lin;
    logic               near_lin;
    logic [1:0]         pair;
    logic signed [31:0] bs;
    logic signed [31:0] bn;
    logic signed [31:0] water;
    logic signed [31:0] twoa;
    logic signed [31:0] depth;
    logic signed [31:0] cc;
    logic signed [31:0] ssq;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] mxx;
    logic signed [31:0] myy;
    logic signed [31:0] csd;
    logic signed [31:0] pxx;
    logic signed [31:0] pyy;
    logic signed [31:0] pxyt;
    logic signed [31:0] diff;
    logic signed [31:0] a1;
    logic signed [31:0] c1;
    logic signed [31:0] d1;
    logic signed [31:0] a2;
    logic signed [31:0] c2;
    logic signed [31:0] d2;
    logic signed [31:0] sn0;
    logic signed [31:0] sh_st;
    logic signed [31:0] nm_st;
    logic signed [31:0] t_s;
    logic signed [31:0] t_n;
    logic signed [31:0] nss;
    logic signed [31:0] nsn;
    logic               wr;
    logic signed [31:0] os;
    logic signed [31:0] on;
    logic signed [31:0] fs;
    logic signed [31:0] fn;
  } item_t;

  logic signed [31:0] surface_level;
  logic signed [31:0] base_stress_xx;
  logic signed [31:0] base_stress_yy;
  logic signed [31:0] base_stress_xy;
  logic signed [31:0] gradient_xx;
  logic signed [31:0] gradient_yy;
  logic [3:0]         lining_material;

  item_t             st      [Stages];
  item_t             st_next [Stages];
  logic [Stages-1:0] vld;

  logic               take;
  logic signed [31:0] two_pxy;
  logic signed [31:0] sub_s;
  logic signed [31:0] sub_n;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;
  assign two_pxy   = qdbl(base_stress_xy);

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_level   <= '0;
      base_stress_xx  <= '0;
      base_stress_yy  <= '0;
      base_stress_xy  <= '0;
      gradient_xx     <= '0;
      gradient_yy     <= '0;
      lining_material <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SURFACE: surface_level   <= cfg_data;
        CFG_BASE_XX: base_stress_xx  <= cfg_data;
        CFG_BASE_YY: base_stress_yy  <= cfg_data;
        CFG_BASE_XY: base_stress_xy  <= cfg_data;
        CFG_GRAD_XX: gradient_xx     <= cfg_data;
        CFG_GRAD_YY: gradient_yy     <= cfg_data;
        CFG_LINING:  lining_material <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // stage 0: capture, depth, angle squares, 2*pxy*s, element length
  always_comb begin
    st_next[0]          = '0;
    st_next[0].idx      = element_index;
    st_next[0].c        = cos_angle;
    st_next[0].s        = sin_angle;
    st_next[0].code     = bc_code;
    st_next[0].lin      = (material == lining_material);
    st_next[0].near_lin = (material == lining_material) ||
                          (next_material == lining_material);
    st_next[0].pair     = pair_flag;
    st_next[0].bs       = rhs_shear_in;
    st_next[0].bn       = rhs_normal_in;
    st_next[0].water    = water_load;
    st_next[0].twoa     = half_length[30] ? Q_MAX : {1'b0, half_length[29:0], 1'b0};
    st_next[0].depth    = qsub(surface_level, elem_y);
    st_next[0].cc       = qmul(32'(cos_angle), 32'(cos_angle));
    st_next[0].ssq      = qmul(32'(sin_angle), 32'(sin_angle));
    st_next[0].b1       = qmul(two_pxy, 32'(sin_angle));
  end

  // stage 1: gradient products, c*c - s*s, 2*pxy*s*c
  always_comb begin
    st_next[1]     = st[0];
    st_next[1].mxx = qmul(gradient_xx, st[0].depth);
    st_next[1].myy = qmul(gradient_yy, st[0].depth);
    st_next[1].csd = qsub(st[0].cc, st[0].ssq);
    st_next[1].b2  = qmul(st[0].b1, 32'(st[0].c));
  end

  // stage 2: in-situ stresses
  always_comb begin
    st_next[2]      = st[1];
    st_next[2].pxx  = qadd(base_stress_xx, st[1].mxx);
    st_next[2].pyy  = qadd(base_stress_yy, st[1].myy);
    st_next[2].pxyt = qmul(base_stress_xy, st[1].csd);
  end

  // stage 3: first rotation products
  always_comb begin
    st_next[3]      = st[2];
    st_next[3].diff = qsub(st[2].pyy, st[2].pxx);
    st_next[3].a1   = qmul(st[2].pxx, 32'(st[2].s));
    st_next[3].c1   = qmul(st[2].pyy, 32'(st[2].c));
  end

  // stage 4: second rotation products
  always_comb begin
    st_next[4]    = st[3];
    st_next[4].d1 = qmul(st[3].diff, 32'(st[3].s));
    st_next[4].a2 = qmul(st[3].a1, 32'(st[3].s));
    st_next[4].c2 = qmul(st[3].c1, 32'(st[3].c));
  end

  // stage 5: last shear product, first normal sum
  always_comb begin
    st_next[5]     = st[4];
    st_next[5].d2  = qmul(st[4].d1, 32'(st[4].c));
    st_next[5].sn0 = qsub(st[4].a2, st[4].b2);
  end

  // stage 6: element shear and normal stress
  always_comb begin
    st_next[6]       = st[5];
    st_next[6].sh_st = qadd(st[5].d2, st[5].pxyt);
    st_next[6].nm_st = qadd(st[5].sn0, st[5].c2);
  end

  // stage 7: subtract from incoming pair, negate for forces
  always_comb begin
    st_next[7]     = st[6];
    st_next[7].t_s = qsub(st[6].bs, st[6].sh_st);
    st_next[7].t_n = qsub(st[6].bn, st[6].nm_st);
    st_next[7].nss = qneg(st[6].sh_st);
    st_next[7].nsn = qneg(st[6].nm_st);
  end

  // stage 8: boundary-code selection and forces
  always_comb begin
    sub_s          = st[7].lin ? st[7].bs : st[7].t_s;
    sub_n          = qsub(st[7].lin ? st[7].bn : st[7].t_n, st[7].water);
    st_next[8]     = st[7];
    st_next[8].wr  = 1'b1;
    st_next[8].os  = '0;
    st_next[8].on  = '0;
    case (st[7].code)
      BC_SUB_A, BC_SUB_B, BC_SUB_C, BC_SUB_D: begin
        st_next[8].os = sub_s;
        st_next[8].on = sub_n;
      end
      BC_PASS_A, BC_PASS_B, BC_PASS_C, BC_PASS_D: begin
        st_next[8].os = st[7].bs;
        st_next[8].on = st[7].bn;
      end
      BC_NORM_A, BC_NORM_B: begin
        st_next[8].os = st[7].bs;
        st_next[8].on = sub_n;
      end
      BC_SHEAR_A, BC_SHEAR_B: begin
        st_next[8].os = sub_s;
        st_next[8].on = st[7].bn;
      end
      BC_JOINT_A, BC_JOINT_B: begin
        if (st[7].near_lin) begin
          if (st[7].pair == PAIR_SUB) begin
            st_next[8].os = st[7].t_s;
            st_next[8].on = st[7].t_n;
          end else if (st[7].pair != PAIR_ZERO) begin
            st_next[8].wr = 1'b0;
          end
        end
      end
      default: st_next[8].wr = 1'b0;
    endcase
    st_next[8].fs = st[7].lin ? '0 : qmul(st[7].twoa, st[7].nss);
    st_next[8].fn = st[7].lin ? '0 : qmul(st[7].twoa, st[7].nsn);
  end

  // advance every stage each cycle; valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Stages-2:0], take};
    end
    for (int i = 0; i < Stages; i++) begin
      st[i] <= st_next[i];
    end
  end

  assign done           = vld[Stages-1];
  assign index_out      = st[Stages-1].idx;
  assign rhs_written    = st[Stages-1].wr;
  assign rhs_shear_out  = st[Stages-1].os;
  assign rhs_normal_out = st[Stages-1].on;
  assign force_shear    = st[Stages-1].fs;
  assign force_normal   = st[Stages-1].fn;

endmodule
